@@ hdl/sdlm_pkg.sv @@
// Shared types and constants for the stereo delay line with dry/wet mix.
// No dependencies; imported by every module of the block.
package sdlm_pkg;

    localparam int RING_DEPTH_DEF  = 131072;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int DELAY_BITS      = 17;
    localparam int MIX_BITS        = 16;
    localparam int GAIN_BITS       = MIX_BITS + 1;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [MIX_BITS-1:0] MIX_ONE = 16'd32768;

    typedef enum logic [0:0] {
        REG_DELAY = 1'b0,
        REG_MIX   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_BITS-1:0] delay;
        logic [MIX_BITS-1:0]   mix;
    } cfg_t;

endpackage

@@ hdl/sdlm_regs.sv @@
// APB register file: frame delay and wet/dry mix.
// Depends on sdlm_pkg.
module sdlm_regs
    import sdlm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DELAY: cfg_next.delay = pwdata[DELAY_BITS-1:0];
                REG_MIX:   cfg_next.mix   = pwdata[MIX_BITS-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DELAY: prdata = {{(APB_DATA_BITS-DELAY_BITS){1'b0}}, cfg_reg.delay};
            REG_MIX:   prdata = {{(APB_DATA_BITS-MIX_BITS){1'b0}}, cfg_reg.mix};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay <= DELAY_BITS'(1);
            cfg_reg.mix   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/sdlm_ring.sv @@
// Circular stereo sample store with write index and fill count; stage one of the pipe.
// Depends on sdlm_pkg.
module sdlm_ring
    import sdlm_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [DELAY_BITS-1:0]         delay,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_dry,
    output logic signed [SAMPLE_BITS-1:0] right_dry,
    output logic signed [SAMPLE_BITS-1:0] left_wet,
    output logic signed [SAMPLE_BITS-1:0] right_wet
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int EW = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
    localparam int MW = 2 * SAMPLE_BITS;

    logic [MW-1:0] mem [RING_DEPTH];

    logic [AW-1:0] widx_reg, widx_next;
    logic [AW:0]   fill_reg, fill_next;
    logic          v1_reg, v1_next;
    logic          hit_reg;
    logic [MW-1:0] rd_reg;
    logic signed [SAMPLE_BITS-1:0] dry_l_reg, dry_r_reg;

    logic          acc;
    logic [EW-1:0] d_ext, d_cl;
    logic [AW-1:0] d_use;
    logic [AW:0]   raddr_wide;
    logic [AW-1:0] raddr;
    logic          hit;

    assign in_ready = !v1_reg || out_ready;
    assign acc      = in_valid && in_ready;

    // clamp delay to 1 .. RING_DEPTH-1
    always_comb begin
        d_ext = EW'(delay);
        if (d_ext == '0) begin
            d_cl = EW'(1);
        end else if (d_ext > EW'(RING_DEPTH - 1)) begin
            d_cl = EW'(RING_DEPTH - 1);
        end else begin
            d_cl = d_ext;
        end
        d_use = d_cl[AW-1:0];
    end

    always_comb begin
        if (widx_reg >= d_use) begin
            raddr_wide = {1'b0, widx_reg} - {1'b0, d_use};
        end else begin
            raddr_wide = {1'b0, widx_reg} + (AW+1)'(RING_DEPTH) - {1'b0, d_use};
        end
        raddr = raddr_wide[AW-1:0];
        // entries not yet written since reset read as zero
        hit   = fill_reg >= {1'b0, d_use};
    end

    always_comb begin
        widx_next = widx_reg;
        fill_next = fill_reg;
        if (acc) begin
            widx_next = (widx_reg == AW'(RING_DEPTH - 1)) ? '0 : widx_reg + AW'(1);
            if (fill_reg != (AW+1)'(RING_DEPTH)) begin
                fill_next = fill_reg + (AW+1)'(1);
            end
        end
        if (acc) begin
            v1_next = 1'b1;
        end else if (out_ready) begin
            v1_next = 1'b0;
        end else begin
            v1_next = v1_reg;
        end
    end

    // read and write never hit the same entry: delay is at least one frame
    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg        <= mem[raddr];
            mem[widx_reg] <= {left_in, right_in};
            hit_reg       <= hit;
            dry_l_reg     <= left_in;
            dry_r_reg     <= right_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg <= '0;
            fill_reg <= '0;
            v1_reg   <= 1'b0;
        end else begin
            widx_reg <= widx_next;
            fill_reg <= fill_next;
            v1_reg   <= v1_next;
        end
    end

    assign out_valid = v1_reg;
    assign left_dry  = dry_l_reg;
    assign right_dry = dry_r_reg;
    assign left_wet  = hit_reg ? $signed(rd_reg[MW-1:SAMPLE_BITS]) : '0;
    assign right_wet = hit_reg ? $signed(rd_reg[SAMPLE_BITS-1:0]) : '0;

endmodule

@@ hdl/sdlm_blend.sv @@
// Dry/wet blend: product stage, then rounded sum into the output register.
// Depends on sdlm_pkg.
module sdlm_blend
    import sdlm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [MIX_BITS-1:0]           mix,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_dry,
    input  logic signed [SAMPLE_BITS-1:0] right_dry,
    input  logic signed [SAMPLE_BITS-1:0] left_wet,
    input  logic signed [SAMPLE_BITS-1:0] right_wet,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int PW = SAMPLE_BITS + GAIN_BITS;
    localparam int SW = PW + 1;

    logic [MIX_BITS-1:0]        m_cl;
    logic signed [GAIN_BITS-1:0] g_wet, g_dry;

    logic signed [PW-1:0] pdl_reg, pwl_reg, pdr_reg, pwr_reg;
    logic signed [SAMPLE_BITS-1:0] ol_reg, or_reg;
    logic v2_reg, v2_next, v3_reg, v3_next;
    logic adv2, adv3;
    logic signed [SW-1:0] sum_l, sum_r;

    assign m_cl  = (mix > MIX_ONE) ? MIX_ONE : mix;
    assign g_wet = $signed({1'b0, m_cl});
    assign g_dry = $signed({1'b0, MIX_ONE - m_cl});

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign in_ready = adv2;

    always_comb begin
        v2_next = adv2 ? in_valid : v2_reg;
        v3_next = adv3 ? v2_reg : v3_reg;
    end

    // arithmetic shift gives the floor of the rounded sum
    always_comb begin
        sum_l = SW'(pdl_reg) + SW'(pwl_reg) + SW'(16384);
        sum_r = SW'(pdr_reg) + SW'(pwr_reg) + SW'(16384);
    end

    always_ff @(posedge aclk) begin
        if (adv2 && in_valid) begin
            pdl_reg <= left_dry * g_dry;
            pwl_reg <= left_wet * g_wet;
            pdr_reg <= right_dry * g_dry;
            pwr_reg <= right_wet * g_wet;
        end
        if (adv3 && v2_reg) begin
            ol_reg <= sum_l[SAMPLE_BITS+14:15];
            or_reg <= sum_r[SAMPLE_BITS+14:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign out_valid = v3_reg;
    assign left_out  = ol_reg;
    assign right_out = or_reg;

endmodule

@@ hdl/stereo_delay_line_mix_top.sv @@
// Stereo delay line with dry/wet mix: top level over sdlm_regs, sdlm_ring and sdlm_blend.
// Pipeline: three register stages; an accepted beat passes the ring read register, then
// the product registers, then the output register, which drives m_valid and the result.
// Throughput: one frame per cycle unless m_ready stalls the output; the sample memory holds
// both channels in one word and takes one read and one write per accepted beat.
// Reset: sync, active low; clears write index, fill count, stage valids, mix; delay set to 1.
module stereo_delay_line_mix_top
    import sdlm_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_BITS-1:0]      paddr,
    input  logic [APB_DATA_BITS-1:0]      pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);

    cfg_t cfg;
    logic st1_valid, st1_ready;
    logic signed [SAMPLE_BITS-1:0] left_dry, right_dry, left_wet, right_wet;

    sdlm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdlm_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .delay     (cfg.delay),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .left_in   (s_left_in),
        .right_in  (s_right_in),
        .out_valid (st1_valid),
        .out_ready (st1_ready),
        .left_dry  (left_dry),
        .right_dry (right_dry),
        .left_wet  (left_wet),
        .right_wet (right_wet)
    );

    sdlm_blend #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mix       (cfg.mix),
        .in_valid  (st1_valid),
        .in_ready  (st1_ready),
        .left_dry  (left_dry),
        .right_dry (right_dry),
        .left_wet  (left_wet),
        .right_wet (right_wet),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .left_out  (m_left_out),
        .right_out (m_right_out)
    );

endmodule

@@ hdl/sdlm_checker.sv @@
// Port-level checks for the stereo delay line top, attached by bind.
// Depends on sdlm_pkg and stereo_delay_line_mix_top.
module sdlm_checker
    import sdlm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   pready,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_left_out,
    input logic [SAMPLE_BITS-1:0] m_right_out
);

    // a reset drains every stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present right after reset");

    // an empty output register means nothing upstream can block
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output register empty");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_out) && $stable(m_right_out))
        else $error("stalled result beat changed");

endmodule

bind stereo_delay_line_mix_top sdlm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sdlm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .pready      (pready),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_left_out  (m_left_out),
    .m_right_out (m_right_out)
);

@@ sim/tb_stereo_delay_line_mix_top.sv @@
// Self-checking testbench for stereo_delay_line_mix_top: a directed script of frames and
// register writes, then random frames over several delay/mix settings with random stalls.
// Depends on sdlm_pkg and the RTL of the block; every result beat is checked in order.
module tb_stereo_delay_line_mix_top;
    import sdlm_pkg::*;

    localparam int DEPTH        = RING_DEPTH_DEF;
    localparam int SW           = SAMPLE_BITS_DEF;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_FRAMES = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int SCRIPT_ROWS  = 26;

    typedef logic [SW-1:0] sample_t;

    localparam sample_t S_MAX = 24'h7FFFFF;
    localparam sample_t S_MIN = 24'h800000;

    typedef enum logic [0:0] {
        ROW_FRAME = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        reg_idx_t                 reg_sel;
        logic [APB_DATA_BITS-1:0] value;
        sample_t                  left;
        sample_t                  right;
        logic                     typed;
        sample_t                  left_exp;
        sample_t                  right_exp;
    } script_row_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [SW-1:0]     s_left_in;
    logic signed [SW-1:0]     s_right_in;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [SW-1:0]     m_left_out;
    logic signed [SW-1:0]     m_right_out;

    // Model state: sample rings, write position and the register copies
    sample_t               left_ring  [DEPTH];
    sample_t               right_ring [DEPTH];
    int unsigned           wr_pos;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [MIX_BITS-1:0]   mix_reg;
    frame_t                mixed_due [$];

    int   fault_count     = 0;
    int   frames_sent     = 0;
    int   results_checked = 0;
    int   writes_done     = 0;
    int   quiet_cycles    = 0;
    int   rx_hold         = 0;
    logic quiet_run       = 1'b0;

    // Reset defaults are dry (mix 0) with a one-frame delay
    script_row_t script [SCRIPT_ROWS] = '{
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000000, 24'h000000, 1'b1, 24'h000000, 24'h000000},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000001, 24'hFFFFFF, 1'b1, 24'h000001, 24'hFFFFFF},
        // fully wet: output is the previous frame
        '{ROW_WRITE, REG_MIX, 32'd32768, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000005, 24'h000006, 1'b1, 24'h000001, 24'hFFFFFF},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MAX, S_MIN, 1'b1, 24'h000005, 24'h000006},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000000, 24'h000000, 1'b1, S_MAX, S_MIN},
        // mix above unity acts as fully wet
        '{ROW_WRITE, REG_MIX, 32'h0000FFFF, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000007, 24'h000007, 1'b1, 24'h000000, 24'h000000},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MIN, S_MAX, 1'b1, 24'h000007, 24'h000007},
        // zero delay acts as one frame
        '{ROW_WRITE, REG_DELAY, 32'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000003, 24'h000003, 1'b1, S_MIN, S_MAX},
        // longest delay reads an entry never written, which must come back zero
        '{ROW_WRITE, REG_DELAY, 32'h0001FFFF, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h123456, 24'hABCDEF, 1'b1, 24'h000000, 24'h000000},
        '{ROW_WRITE, REG_MIX, 32'd16384, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_WRITE, REG_DELAY, 32'd2, '0, '0, 1'b0, '0, '0},
        '{ROW_WRITE, REG_MIX, 32'd1, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MIN, S_MAX, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h400000, 24'hC00000, 1'b0, '0, '0},
        '{ROW_WRITE, REG_MIX, 32'd32767, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'h000000, 24'h000000, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_FRAME, REG_DELAY, 32'd0, 24'hFFFFFF, 24'h000001, 1'b0, '0, '0}
    };

    stereo_delay_line_mix_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_left_in  (s_left_in),
        .s_right_in (s_right_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_left_out (m_left_out),
        .m_right_out(m_right_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Floor of the Q15 blend with rounding offset; arithmetic shift floors negatives
    function automatic sample_t blend_sample(sample_t dry, sample_t wet, int unsigned wet_wt);
        longint acc;
        acc = longint'(signed'(dry)) * (32768 - longint'(wet_wt))
            + longint'(signed'(wet)) * longint'(wet_wt) + 16384;
        acc = acc >>> 15;
        return acc[SW-1:0];
    endfunction

    function automatic frame_t predict_mix(sample_t left, sample_t right);
        int unsigned d;
        int unsigned g;
        int unsigned rd;
        frame_t      res;
        d = 32'(delay_reg);
        if (d < 1) d = 1;
        if (d > DEPTH - 1) d = DEPTH - 1;
        g = (mix_reg > MIX_ONE) ? 32'(MIX_ONE) : 32'(mix_reg);
        rd = (wr_pos + DEPTH - d) % DEPTH;
        res.left  = blend_sample(left, left_ring[rd], g);
        res.right = blend_sample(right, right_ring[rd], g);
        left_ring[wr_pos]  = left;
        right_ring[wr_pos] = right;
        wr_pos = (wr_pos + 1) % DEPTH;
        return res;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (quiet_run || $urandom_range(0, 99) < 55) return 0;
        return idle_len();
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return SW'($urandom_range(0, 31) - 16);
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    task automatic send_frame(sample_t left, sample_t right, logic typed,
                              sample_t left_exp, sample_t right_exp);
        int     gap;
        frame_t due;
        gap = pick_gap();
        due = predict_mix(left, right);
        if (typed) begin
            due.left  = left_exp;
            due.right = right_exp;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        mixed_due.push_back(due);
        s_valid    <= 1'b1;
        s_left_in  <= left;
        s_right_in <= right;
        do @(posedge aclk); while (!s_ready);
        frames_sent++;
    endtask

    // Drop valid and hold until every expected beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (mixed_due.size() != 0);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        // register i sits at byte address 4*i
        paddr   <= APB_ADDR_BITS'(idx) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DELAY) delay_reg = value[DELAY_BITS-1:0];
        else mix_reg = value[MIX_BITS-1:0];
        writes_done++;
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (quiet_run || $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
            rx_hold <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b0;
            rx_hold <= idle_len() - 1;
        end
    end

    always @(posedge aclk) begin
        frame_t due;
        if (aresetn && m_valid && m_ready) begin
            if (mixed_due.size() == 0) begin
                note_fault($sformatf("result beat with nothing expected: L=%h R=%h",
                                     m_left_out, m_right_out));
            end else begin
                due = mixed_due.pop_front();
                results_checked++;
                if (m_left_out !== due.left)
                    note_fault($sformatf("result %0d left_out: expected %h, got %h",
                                         results_checked, due.left, m_left_out));
                if (m_right_out !== due.right)
                    note_fault($sformatf("result %0d right_out: expected %h, got %h",
                                         results_checked, due.right, m_right_out));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("stereo_delay_line_mix_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [APB_DATA_BITS-1:0] next_delay;
        logic [APB_DATA_BITS-1:0] next_mix;
        aresetn    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        s_valid    <= 1'b0;
        s_left_in  <= '0;
        s_right_in <= '0;
        m_ready    <= 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            left_ring[i]  = '0;
            right_ring[i] = '0;
        end
        wr_pos    = 0;
        delay_reg = 1;
        mix_reg   = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(script[i].reg_sel, script[i].value);
            end else begin
                send_frame(script[i].left, script[i].right, script[i].typed,
                           script[i].left_exp, script[i].right_exp);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            quiet_run = (p == 1);
            case ($urandom_range(0, 9))
                0:          next_delay = 0;
                1:          next_delay = 32'h0001FFFF;
                2, 3, 4, 5: next_delay = $urandom_range(1, 8);
                default:    next_delay = $urandom_range(9, 120);
            endcase
            case ($urandom_range(0, 5))
                0:       next_mix = 0;
                1:       next_mix = 32'(MIX_ONE);
                2:       next_mix = $urandom_range(32769, 65535);
                default: next_mix = $urandom_range(0, 32768);
            endcase
            write_reg(REG_DELAY, next_delay);
            write_reg(REG_MIX, next_mix);
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                if (p == 2 && k == PHASE_FRAMES / 2) wait_drained();
                send_frame(random_sample(), random_sample(), 1'b0, '0, '0);
            end
        end
        quiet_run = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mixed_due.size() != 0)
            note_fault($sformatf("%0d expected results never arrived", mixed_due.size()));

        $display("Sent %0d frames through %0d register writes (%0d random settings).",
                 frames_sent, writes_done, RAND_PHASES);
        $display("Checked %0d blended result beats; %0d mismatches.",
                 results_checked, fault_count);
        if (fault_count == 0) begin
            $display("stereo_delay_line_mix_top verification clean");
        end else begin
            $display("stereo_delay_line_mix_top verification failed");
        end
        $finish;
    end

endmodule
